>>> hw/rtl/vce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vce_pkg;

  // Volume geometry and energy format
  localparam int TILE      = 64;
  localparam int DEPTH     = 16;
  localparam int FRAC_BITS = 16;

  localparam int XW    = $clog2(TILE);
  localparam int ZW    = $clog2(DEPTH);
  localparam int CELLS = DEPTH * TILE * TILE;
  localparam int AW    = $clog2(CELLS);
  localparam int EW    = 32;

  // Gaussian kernel table: entries for squared distances below KTAB
  localparam int KTAB = 192;
  localparam int KIW  = $clog2(KTAB);
  localparam int KW   = FRAC_BITS + 1;
  localparam int PW   = KW + 2;

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] CFG_STRIDED = 1'b0;

  // Command codes
  localparam logic [1:0] FN_SET = 2'd0;
  localparam logic [1:0] FN_CLR = 2'd1;
  localparam logic [1:0] FN_INV = 2'd2;
  localparam logic [1:0] FN_NOP = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] pos_x;
    logic [5:0] pos_y;
    logic [3:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic [15:0] void_index;
    logic        void_found;
    logic [15:0] cluster_index;
    logic        cluster_found;
  } out_item_t;

  typedef logic [KW-1:0] ktab_t [KTAB];

  localparam longint unsigned ONE31 = 64'd2147483648;
  localparam longint unsigned EXP_C = (ONE31 * 64'd100 + 64'd361) / 64'd722;

  // exp(-1/7.22) by a 12-term series in Q1.31, then powers of it, rounded to Q.FRAC_BITS
  function automatic ktab_t build_ktab();
    longint unsigned term;
    longint unsigned e;
    longint unsigned g;
    ktab_t           tab;
    term = ONE31;
    e    = ONE31;
    term = ((term * EXP_C) >> 31) / 64'd1;
    e    = e - term;
    term = ((term * EXP_C) >> 31) / 64'd2;
    e    = e + term;
    term = ((term * EXP_C) >> 31) / 64'd3;
    e    = e - term;
    term = ((term * EXP_C) >> 31) / 64'd4;
    e    = e + term;
    term = ((term * EXP_C) >> 31) / 64'd5;
    e    = e - term;
    term = ((term * EXP_C) >> 31) / 64'd6;
    e    = e + term;
    term = ((term * EXP_C) >> 31) / 64'd7;
    e    = e - term;
    term = ((term * EXP_C) >> 31) / 64'd8;
    e    = e + term;
    term = ((term * EXP_C) >> 31) / 64'd9;
    e    = e - term;
    term = ((term * EXP_C) >> 31) / 64'd10;
    e    = e + term;
    term = ((term * EXP_C) >> 31) / 64'd11;
    e    = e - term;
    term = ((term * EXP_C) >> 31) / 64'd12;
    e    = e + term;
    g = ONE31;
    tab[0] = KW'((g + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS));
    for (int n = 1; n < KTAB; n++) begin
      g = (g * e + (ONE31 >> 1)) >> 31;
      tab[n] = KW'((g + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS));
    end
    return tab;
  endfunction

  localparam ktab_t KERN_TAB = build_ktab();

endpackage

`default_nettype wire

>>> hw/rtl/void_cluster_energy_splat.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                     Transaction
// in        in_valid, in_ready, in_data               one command (func, pos_x/y/z)
// out       out_valid, out_ready, out_data            void and cluster of the volume
// cfg       psel, penable, pwrite, paddr, pwdata,     strided_mode at address 0
//           prdata, pready
//
// A command is accepted only in idle; its result follows a scan of all CELLS cells:
// one cell per cycle streams through a 6-stage update pipeline and a 1R1W energy RAM.
// After reset a clearing pass writes all 65536 cells, one a cycle; in_ready stays low.
// A result that is not taken holds the next result back; a new command is still accepted
// while an earlier result waits on out.

module void_cluster_energy_splat (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire vce_pkg::in_item_t       in_data,
  output logic                         out_valid,
  input  wire                          out_ready,
  output vce_pkg::out_item_t           out_data,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [vce_pkg::CFG_AW-1:0]    paddr,
  input  wire [vce_pkg::CFG_DW-1:0]    pwdata,
  output logic [vce_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import vce_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_WAIT  = 2'd3;

  localparam int NSTG      = 6;
  localparam int RECIP3    = 43;   // floor(v*43/128) == v/3 for v up to TILE/2
  localparam int RECIP3_SH = 7;
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

  function automatic logic [XW-1:0] wrap_xy(input logic [XW-1:0] a, input logic [XW-1:0] b);
    logic [XW-1:0] m;
    logic [XW-1:0] n;
    m = a - b;
    n = ~m + 1'b1;
    return (m < n) ? m : n;
  endfunction

  function automatic logic [ZW-1:0] wrap_z(input logic [ZW-1:0] a, input logic [ZW-1:0] b);
    logic [ZW-1:0] m;
    logic [ZW-1:0] n;
    m = a - b;
    n = ~m + 1'b1;
    return (m < n) ? m : n;
  endfunction

  function automatic logic [2*XW-2:0] sq_xy(input logic [XW-1:0] v);
    logic [2*XW-1:0] p;
    p = (2*XW)'(v) * (2*XW)'(v);
    return p[2*XW-2:0];
  endfunction

  // control
  logic [1:0]      state_r, state_nxt;
  logic [AW-1:0]   cnt_r, cnt_nxt;
  logic            iss_r;
  logic [NSTG-1:0] vld_r, lst_r;
  logic            strided_r;
  in_item_t        cmd_r;
  out_item_t       out_r;
  logic            out_valid_r;

  logic in_fire, cfg_we, issue, scan_done, out_load;

  // pipeline payload
  logic [XW-1:0] s1_dx_r, s1_dy_r;
  logic [ZW-1:0] s1_dz_r;
  logic          s1_same_r, s1_col_r;
  logic [AW-1:0] s1_addr_r;

  logic [XW-1:0] s2_dx_r, s2_dy_r, s2_hx_r, s2_hy_r, s2_tx_r, s2_ty_r, s2_fx_r, s2_fy_r;
  logic          s2_div2_r, s2_div3_r, s2_div4_r;
  logic [ZW-1:0] s2_dz_r;
  logic          s2_same_r, s2_col_r;
  logic [AW-1:0] s2_addr_r;

  logic [KIW-1:0] s3_k1_r, s3_k2_r, s3_k3_r, s3_k4_r, s3_kz_r;
  logic [4:0]     s3_en_r;
  logic [AW-1:0]  s3_addr_r;

  logic [KW-1:0] s4_t1_r, s4_t2_r, s4_t3_r, s4_t4_r, s4_tz_r;
  logic [AW-1:0] s4_addr_r;

  logic [PW-1:0] s5_p_r;
  logic [AW-1:0] s5_addr_r;

  logic signed [EW-1:0] s6_e_r;
  logic                 s6_m_r;
  logic [AW-1:0]        s6_addr_r;

  // best-so-far
  logic                 vf_r, cf_r;
  logic signed [EW-1:0] vmin_r, cmax_r;
  logic [AW-1:0]        vidx_r, cidx_r;

  // energy/mark RAM: {mark, energy}
  logic [EW:0]   mem [CELLS];
  logic [EW:0]   rd_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [EW:0]   mem_wd;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign issue     = (state_r == ST_SCAN) && iss_r;
  assign scan_done = vld_r[NSTG-1] && lst_r[NSTG-1];
  assign out_load  = (state_r == ST_WAIT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[CFG_AW-1:2] == CFG_STRIDED);
  assign prdata = (paddr[CFG_AW-1:2] == CFG_STRIDED) ? CFG_DW'(strided_r) : '0;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CELL) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (iss_r) cnt_nxt = cnt_r + 1'b1;
        if (scan_done) state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      iss_r       <= 1'b0;
      vld_r       <= '0;
      lst_r       <= '0;
      strided_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      vld_r   <= {vld_r[NSTG-2:0], issue};
      lst_r   <= {lst_r[NSTG-2:0], issue && (cnt_r == LAST_CELL)};
      if (in_fire) begin
        iss_r <= 1'b1;
      end else if (issue && (cnt_r == LAST_CELL)) begin
        iss_r <= 1'b0;
      end
      if (cfg_we) strided_r <= pwdata[0];
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) cmd_r <= in_data;
    if (out_load) begin
      out_r.void_index    <= 16'(vidx_r);
      out_r.void_found    <= vf_r;
      out_r.cluster_index <= 16'(cidx_r);
      out_r.cluster_found <= cf_r;
    end
  end

  // stage 1: wrapped distances of the issued cell
  always_ff @(posedge clk) begin
    s1_dx_r   <= wrap_xy(cnt_r[XW-1:0], cmd_r.pos_x);
    s1_dy_r   <= wrap_xy(cnt_r[2*XW-1:XW], cmd_r.pos_y);
    s1_dz_r   <= wrap_z(cnt_r[AW-1:2*XW], cmd_r.pos_z);
    s1_same_r <= (cnt_r[AW-1:2*XW] == cmd_r.pos_z);
    s1_col_r  <= (cnt_r[XW-1:0] == cmd_r.pos_x) && (cnt_r[2*XW-1:XW] == cmd_r.pos_y);
    s1_addr_r <= cnt_r;
  end

  // stage 2: stride quotients and divisibility
  logic [XW+5:0] mx3, my3;
  logic [XW-1:0] qx3, qy3, rx3, ry3;

  always_comb begin
    mx3 = (XW+6)'(s1_dx_r) * (XW+6)'(RECIP3);
    my3 = (XW+6)'(s1_dy_r) * (XW+6)'(RECIP3);
    qx3 = XW'(mx3 >> RECIP3_SH);
    qy3 = XW'(my3 >> RECIP3_SH);
    rx3 = s1_dx_r - (qx3 + qx3 + qx3);
    ry3 = s1_dy_r - (qy3 + qy3 + qy3);
  end

  always_ff @(posedge clk) begin
    s2_dx_r   <= s1_dx_r;
    s2_dy_r   <= s1_dy_r;
    s2_hx_r   <= s1_dx_r >> 1;
    s2_hy_r   <= s1_dy_r >> 1;
    s2_tx_r   <= qx3;
    s2_ty_r   <= qy3;
    s2_fx_r   <= s1_dx_r >> 2;
    s2_fy_r   <= s1_dy_r >> 2;
    s2_div2_r <= !s1_dx_r[0] && !s1_dy_r[0];
    s2_div3_r <= (rx3 == '0) && (ry3 == '0);
    s2_div4_r <= (s1_dx_r[1:0] == 2'b00) && (s1_dy_r[1:0] == 2'b00);
    s2_dz_r   <= s1_dz_r;
    s2_same_r <= s1_same_r;
    s2_col_r  <= s1_col_r;
    s2_addr_r <= s1_addr_r;
  end

  // stage 3: squared distances and kernel term enables
  logic [2*XW-1:0] d2_1, d2_2, d2_3, d2_4;
  logic [2*ZW-1:0] d2_z;

  always_comb begin
    d2_1 = {1'b0, sq_xy(s2_dx_r)} + {1'b0, sq_xy(s2_dy_r)};
    d2_2 = {1'b0, sq_xy(s2_hx_r)} + {1'b0, sq_xy(s2_hy_r)};
    d2_3 = {1'b0, sq_xy(s2_tx_r)} + {1'b0, sq_xy(s2_ty_r)};
    d2_4 = {1'b0, sq_xy(s2_fx_r)} + {1'b0, sq_xy(s2_fy_r)};
    d2_z = (2*ZW)'(s2_dz_r) * (2*ZW)'(s2_dz_r);
  end

  always_ff @(posedge clk) begin
    s3_k1_r    <= d2_1[KIW-1:0];
    s3_k2_r    <= d2_2[KIW-1:0];
    s3_k3_r    <= d2_3[KIW-1:0];
    s3_k4_r    <= d2_4[KIW-1:0];
    s3_kz_r    <= KIW'(d2_z);
    s3_en_r[0] <= s2_same_r && (d2_1 < (2*XW)'(KTAB));
    s3_en_r[1] <= s2_same_r && strided_r && s2_div2_r && (d2_2 < (2*XW)'(KTAB));
    s3_en_r[2] <= s2_same_r && strided_r && s2_div3_r && (d2_3 < (2*XW)'(KTAB));
    s3_en_r[3] <= s2_same_r && strided_r && s2_div4_r && (d2_4 < (2*XW)'(KTAB));
    s3_en_r[4] <= !s2_same_r && s2_col_r && ({1'b0, d2_z} < (2*ZW+1)'(KTAB));
    s3_addr_r  <= s2_addr_r;
  end

  // stage 4: kernel lookups
  always_ff @(posedge clk) begin
    s4_t1_r   <= s3_en_r[0] ? KERN_TAB[s3_k1_r] : '0;
    s4_t2_r   <= s3_en_r[1] ? KERN_TAB[s3_k2_r] : '0;
    s4_t3_r   <= s3_en_r[2] ? KERN_TAB[s3_k3_r] : '0;
    s4_t4_r   <= s3_en_r[3] ? KERN_TAB[s3_k4_r] : '0;
    s4_tz_r   <= s3_en_r[4] ? KERN_TAB[s3_kz_r] : '0;
    s4_addr_r <= s3_addr_r;
  end

  // stage 5: proximity sum; cell word read lands alongside
  logic [PW-1:0] tz_scaled;

  assign tz_scaled = strided_r ? {s4_tz_r, 2'b00} : {2'b00, s4_tz_r};

  always_ff @(posedge clk) begin
    s5_p_r    <= PW'(s4_t1_r) + PW'(s4_t2_r) + PW'(s4_t3_r) + PW'(s4_t4_r) + tz_scaled;
    s5_addr_r <= s4_addr_r;
  end

  // stage 6: saturating update and write-back
  logic signed [EW-1:0] e_old, e_sat, e_new;
  logic                 m_old, m_new;
  logic [EW:0]          e_sum;
  logic [AW-1:0]        org_addr;

  assign e_old    = rd_r[EW-1:0];
  assign m_old    = rd_r[EW];
  assign org_addr = {cmd_r.pos_z, cmd_r.pos_y, cmd_r.pos_x};

  always_comb begin
    if (cmd_r.func == FN_CLR) begin
      e_sum = {e_old[EW-1], e_old} - (EW+1)'(s5_p_r);
    end else begin
      e_sum = {e_old[EW-1], e_old} + (EW+1)'(s5_p_r);
    end
    if (e_sum[EW] != e_sum[EW-1]) begin
      e_sat = e_sum[EW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    end else begin
      e_sat = e_sum[EW-1:0];
    end
    case (cmd_r.func)
      FN_SET, FN_CLR: begin
        e_new = e_sat;
        m_new = (s5_addr_r == org_addr) ? (cmd_r.func == FN_SET) : m_old;
      end
      FN_INV: begin
        e_new = '0;
        m_new = ~m_old;
      end
      default: begin
        e_new = e_old;
        m_new = m_old;
      end
    endcase
  end

  assign mem_we = (state_r == ST_CLEAR) || (vld_r[NSTG-2] && (cmd_r.func != FN_NOP));
  assign mem_wa = (state_r == ST_CLEAR) ? cnt_r : s5_addr_r;
  assign mem_wd = (state_r == ST_CLEAR) ? '0 : {m_new, e_new};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[s4_addr_r];
  end

  always_ff @(posedge clk) begin
    s6_e_r    <= e_new;
    s6_m_r    <= m_new;
    s6_addr_r <= s5_addr_r;
  end

  // void / cluster search; strict compares keep the lowest index on ties
  always_ff @(posedge clk) begin
    if (!rst_n || in_fire) begin
      vf_r   <= 1'b0;
      cf_r   <= 1'b0;
      vmin_r <= '0;
      cmax_r <= '0;
      vidx_r <= '0;
      cidx_r <= '0;
    end else if (vld_r[NSTG-1]) begin
      if (s6_m_r) begin
        if (!cf_r || (s6_e_r > cmax_r)) begin
          cf_r   <= 1'b1;
          cmax_r <= s6_e_r;
          cidx_r <= s6_addr_r;
        end
      end else begin
        if (!vf_r || (s6_e_r < vmin_r)) begin
          vf_r   <= 1'b1;
          vmin_r <= s6_e_r;
          vidx_r <= s6_addr_r;
        end
      end
    end
  end

  a_ready_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (vld_r == '0))
    else $error("command accepted with cells still in the pipeline");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_IDLE) || (state_r == ST_WAIT)) |-> !mem_we)
    else $error("RAM written outside a scan or clearing pass");

  a_done_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |=> (state_r == ST_WAIT))
    else $error("last cell left the pipeline without ending the scan");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("result not presented after scan");

  a_void_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.void_found) |-> (out_r.void_index == '0))
    else $error("void index nonzero without a void");

endmodule

`default_nettype wire
